// ===== rtl/mfv_pkg.sv =====
package mfv_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned FREQ_W  = 7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] mode_value;
      logic [FREQ_W-1:0]         frequency;
      logic                      overflow;
      logic                      last_result;
   } rsp_type;

endpackage

// ===== rtl/most_frequent_values.sv =====
// Mode finder with ties.
// Input: a set of values arrives one transaction at a time on req_data
// (value, last_item); a transaction is taken on a clock edge with start high
// and busy low. Values are compared on their low VALUE_WIDTH bits.
// Each value is looked up in a table of distinct values held in one RAM, one
// entry per cycle through the registered read port, then its count is
// written back or a new entry is claimed; the table holds at most
// MAX_ELEMENTS distinct values.
// After the transaction marked last, the table is scanned once for the
// greatest count, then once per modal value to pick the next larger one.
// Each result shows on rsp_data for a single cycle with rsp_valid high, in
// ascending order, the final one flagged. Results cannot be held off.
// Transactions beyond MAX_ELEMENTS in a set are dropped and set the overflow
// flag; a dropped last transaction still ends the set. After the final
// result the table is empty again.
// Reset empties the table at once; no clearing pass is needed.
module most_frequent_values #(
   parameter int unsigned MAX_ELEMENTS = 64,
   parameter int unsigned VALUE_WIDTH  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mfv_pkg::req_type req_data,
   output logic            rsp_valid,
   output mfv_pkg::rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(MAX_ELEMENTS);
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned DW = VALUE_WIDTH + CW;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_MAX    = 4'b0100,
      ST_PICK   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                   last_ff, last_in;
   logic [CW-1:0]          ra_ff, ra_in;
   logic                   pv_ff, pv_in;
   logic [AW-1:0]          pidx_ff, pidx_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [CW-1:0]          seen_ff, seen_in;
   logic                   drop_ff, drop_in;
   logic [CW-1:0]          best_ff, best_in;
   logic [CW-1:0]          nties_ff, nties_in;
   logic [CW-1:0]          emit_ff, emit_in;
   logic [VALUE_WIDTH-1:0] prev_ff, prev_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   cand_v_ff, cand_v_in;
   logic [VALUE_WIDTH-1:0] cand_key_ff, cand_key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mfv_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DW-1:0]          wr_data;
   logic                   rd_en;
   logic [DW-1:0]          rd_data;
   logic [VALUE_WIDTH-1:0] rd_key;
   logic [CW-1:0]          rd_cnt;
   logic                   issue;
   logic                   scan_done;
   logic                   is_last;
   logic [63:0]            wide_key;

   mfv_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ELEMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ra_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_key    = rd_data[CW +: VALUE_WIDTH];
   assign rd_cnt    = rd_data[CW-1:0];
   assign issue     = (ra_ff != used_ff);
   assign scan_done = !issue && !pv_ff;
   assign is_last   = (emit_ff == nties_ff - CW'(1));
   assign wide_key  = 64'($signed(cand_key_ff));

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      ra_in        = ra_ff;
      pv_in        = pv_ff;
      pidx_in      = pidx_ff;
      used_in      = used_ff;
      seen_in      = seen_ff;
      drop_in      = drop_ff;
      best_in      = best_ff;
      nties_in     = nties_ff;
      emit_in      = emit_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      cand_v_in    = cand_v_ff;
      cand_key_in  = cand_key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff;
      wr_data      = {key_ff, rd_cnt + CW'(1)};
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in  = VALUE_WIDTH'($signed(req_data.value));
               last_in = req_data.last_item;
               ra_in   = '0;
               pv_in   = 1'b0;
               if (seen_ff < CW'(MAX_ELEMENTS)) begin
                  state_in = ST_SEARCH;
               end else begin
                  drop_in = 1'b1;
                  if (req_data.last_item) begin
                     best_in  = '0;
                     nties_in = '0;
                     state_in = ST_MAX;
                  end
               end
            end
         end
         ST_SEARCH: begin
            rd_en = issue;
            if (pv_ff && rd_key == key_ff) begin
               // hit: bump the count in place
               wr_en   = 1'b1;
               wr_addr = pidx_ff;
               wr_data = {key_ff, rd_cnt + CW'(1)};
            end else if (scan_done) begin
               wr_en   = 1'b1;
               wr_addr = used_ff[AW-1:0];
               wr_data = {key_ff, CW'(1)};
               used_in = used_ff + CW'(1);
            end else begin
               pv_in   = issue;
               pidx_in = ra_ff[AW-1:0];
               if (issue) begin
                  ra_in = ra_ff + CW'(1);
               end
            end
            if (wr_en) begin
               seen_in = seen_ff + CW'(1);
               ra_in   = '0;
               pv_in   = 1'b0;
               if (last_ff) begin
                  best_in  = '0;
                  nties_in = '0;
                  state_in = ST_MAX;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MAX: begin
            rd_en = issue;
            pv_in = issue;
            if (issue) begin
               ra_in = ra_ff + CW'(1);
            end
            if (pv_ff) begin
               if (rd_cnt > best_ff) begin
                  best_in  = rd_cnt;
                  nties_in = CW'(1);
               end else if (rd_cnt == best_ff) begin
                  nties_in = nties_ff + CW'(1);
               end
            end
            if (scan_done) begin
               ra_in        = '0;
               pv_in        = 1'b0;
               have_prev_in = 1'b0;
               cand_v_in    = 1'b0;
               emit_in      = '0;
               state_in     = ST_PICK;
            end
         end
         ST_PICK: begin
            rd_en = issue;
            pv_in = issue;
            if (issue) begin
               ra_in = ra_ff + CW'(1);
            end
            // smallest modal value above the one emitted last
            if (pv_ff && rd_cnt == best_ff
                && (!have_prev_ff || $signed(rd_key) > $signed(prev_ff))
                && (!cand_v_ff || $signed(rd_key) < $signed(cand_key_ff))) begin
               cand_v_in   = 1'b1;
               cand_key_in = rd_key;
            end
            if (scan_done) begin
               rsp_valid_in       = 1'b1;
               rsp_in.mode_value  = wide_key[mfv_pkg::VALUE_W-1:0];
               rsp_in.frequency   = mfv_pkg::FREQ_W'(best_ff);
               rsp_in.overflow    = drop_ff;
               rsp_in.last_result = is_last;
               ra_in              = '0;
               pv_in              = 1'b0;
               if (is_last) begin
                  used_in  = '0;
                  seen_in  = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in      = emit_ff + CW'(1);
                  prev_in      = cand_key_ff;
                  have_prev_in = 1'b1;
                  cand_v_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         seen_ff      <= '0;
         drop_ff      <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         seen_ff      <= seen_in;
         drop_ff      <= drop_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      last_ff      <= last_in;
      ra_ff        <= ra_in;
      pidx_ff      <= pidx_in;
      best_ff      <= best_in;
      nties_ff     <= nties_in;
      emit_ff      <= emit_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      cand_v_ff    <= cand_v_in;
      cand_key_ff  <= cand_key_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/mfv_ram.sv =====
module mfv_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mfv_checker.sv =====
module mfv_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input mfv_pkg::rsp_type rsp_data
);

   logic accepted;

   assign accepted = start && !busy;

   // a set takes at least one table scan before its first result
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accepted |=> !rsp_valid)
      else $error("result right after an accepted transaction");

   a_gap_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |=> !rsp_valid)
      else $error("result directly after the final result");

   a_busy_between_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |=> busy)
      else $error("block went idle with results outstanding");

   a_freq_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frequency != '0)
      else $error("result with zero frequency");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("activity right after reset");

endmodule

bind most_frequent_values mfv_checker u_mfv_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int unsigned TABLE_DEPTH  = 64;
   localparam int unsigned DRAIN_CYCLES = 80;

   typedef logic signed [mfv_pkg::VALUE_W-1:0] value_type;

   localparam value_type MOST_NEG = {1'b1, {(mfv_pkg::VALUE_W-1){1'b0}}};
   localparam value_type MOST_POS = {1'b0, {(mfv_pkg::VALUE_W-1){1'b1}}};

   // Tracks the distinct-value table and queues the modal values of each set.
   class mode_scoreboard;
      value_type        entry_value [TABLE_DEPTH];
      int unsigned      entry_count [TABLE_DEPTH];
      int unsigned      distinct_used;
      int unsigned      elements_seen;
      bit               dropped;
      mfv_pkg::rsp_type expected_modes [$];
      int unsigned      failures;

      function new();
         failures = 0;
         clear_set();
      endfunction

      function void clear_set();
         foreach (entry_count[i]) entry_count[i] = 0;
         distinct_used = 0;
         elements_seen = 0;
         dropped       = 1'b0;
      endfunction

      function void note_request(mfv_pkg::req_type r);
         value_type        picks [$];
         value_type        v;
         value_type        x;
         int unsigned      best;
         int               j;
         bit               found;
         mfv_pkg::rsp_type e;
         v     = r.value;
         best  = 0;
         found = 1'b0;
         if (elements_seen < TABLE_DEPTH) begin
            for (int unsigned i = 0; i < distinct_used; i++) begin
               if (!found && entry_value[i] == v) begin
                  entry_count[i]++;
                  found = 1'b1;
               end
            end
            if (!found) begin
               entry_value[distinct_used] = v;
               entry_count[distinct_used] = 1;
               distinct_used++;
            end
            elements_seen++;
         end else begin
            dropped = 1'b1;
         end
         if (!r.last_item) return;

         for (int unsigned i = 0; i < distinct_used; i++)
            if (entry_count[i] > best) best = entry_count[i];

         // insertion sort keeps the modal values in ascending signed order
         for (int unsigned i = 0; i < distinct_used; i++) begin
            if (entry_count[i] == best) begin
               x = entry_value[i];
               j = picks.size();
               picks.push_back(x);
               while (j > 0 && x < picks[j-1]) begin
                  picks[j] = picks[j-1];
                  j--;
               end
               picks[j] = x;
            end
         end

         for (int k = 0; k < picks.size(); k++) begin
            e.mode_value  = picks[k];
            e.frequency   = mfv_pkg::FREQ_W'(best);
            e.overflow    = dropped;
            e.last_result = (k == picks.size() - 1);
            expected_modes.push_back(e);
         end
         clear_set();
      endfunction

      function void check_result(mfv_pkg::rsp_type got);
         mfv_pkg::rsp_type e;
         if (expected_modes.size() == 0) begin
            $error("unexpected result: mode_value %0d frequency %0d",
                   got.mode_value, got.frequency);
            failures++;
            return;
         end
         e = expected_modes.pop_front();
         if (got.mode_value !== e.mode_value) begin
            $error("mode_value: expected %0d, got %0d", e.mode_value, got.mode_value);
            failures++;
         end
         if (got.frequency !== e.frequency) begin
            $error("frequency: expected %0d, got %0d", e.frequency, got.frequency);
            failures++;
         end
         if (got.overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, got.overflow);
            failures++;
         end
         if (got.last_result !== e.last_result) begin
            $error("last_result: expected %0d, got %0d", e.last_result, got.last_result);
            failures++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   mfv_pkg::req_type req_data;
   logic             rsp_valid;
   mfv_pkg::rsp_type rsp_data;

   mode_scoreboard scoreboard;
   bit             quiet;
   int unsigned    sent_count;

   most_frequent_values dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) scoreboard.check_result(rsp_data);
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic value_type pick_raw();
      case ($urandom_range(0, 5))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return value_type'($urandom_range(0, 8)) - value_type'(4);
         default: return value_type'($urandom);
      endcase
   endfunction

   // Holds start until the transaction is taken, then maybe idles a burst.
   task automatic send_item(input value_type v, input bit last);
      mfv_pkg::req_type r;
      r.value     = v;
      r.last_item = last;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      scoreboard.note_request(r);
      sent_count++;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Mostly draws from a small pool so repeats and ties are common.
   task automatic send_set(input int unsigned n, input bit spread);
      value_type   pool [4];
      int unsigned pool_top;
      value_type   v;
      foreach (pool[i]) pool[i] = pick_raw();
      pool_top = $urandom_range(0, 3);
      for (int unsigned k = 0; k < n; k++) begin
         v = spread ? pick_raw() : pool[$urandom_range(0, pool_top)];
         send_item(v, k == n - 1);
      end
   endtask

   initial begin
      scoreboard = new();
      quiet      = 1'b0;
      sent_count = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-element sets at both extremes
      send_item(MOST_NEG, 1'b1);
      send_item(MOST_POS, 1'b1);
      // two-way tie across zero
      send_item(0, 1'b0);
      send_item(-1, 1'b0);
      send_item(0, 1'b0);
      send_item(-1, 1'b0);
      send_item(7, 1'b1);
      // every value ties at one, mixed signs
      send_item(3, 1'b0);
      send_item(-2, 1'b0);
      send_item(100, 1'b0);
      send_item(MOST_NEG, 1'b0);
      send_item(MOST_POS, 1'b1);
      // one clear winner
      send_item(42, 1'b0);
      send_item(42, 1'b0);
      send_item(42, 1'b1);
      send_item(MOST_POS, 1'b0);
      send_item(MOST_NEG, 1'b0);
      send_item(MOST_NEG, 1'b1);

      // table full of distinct values: every one is modal
      for (int unsigned k = 0; k < TABLE_DEPTH; k++)
         send_item(value_type'(k * 32'h0400_0001 + 32'h1234_5678), k == TABLE_DEPTH - 1);
      // capacity exceeded, the final last-marked transaction dropped too
      send_set(TABLE_DEPTH + 3, 1'b0);

      while (sent_count < 220)
         send_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      quiet = 1'b1;
      while (sent_count < 260)
         send_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      start <= 1'b0;

      while (scoreboard.expected_modes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.failures == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== most_frequent_values.f =====
rtl/mfv_pkg.sv
rtl/mfv_ram.sv
rtl/most_frequent_values.sv
rtl/mfv_checker.sv
tb/tb.sv
